// ===== rtl/ttls_pkg.sv =====
// ----------------------------------------------------------------------------
// ttls_pkg
// types and constants for the transform to local space block
// ----------------------------------------------------------------------------
`default_nettype none

package ttls_pkg;

  localparam int POS_W = 24;
  localparam int ROT_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_W = 3'd6;

  localparam logic signed [ROT_W-1:0] ROT_ONE = 16'sd16384;

  typedef struct packed {
    logic signed [POS_W-1:0] child_pos_x;
    logic signed [POS_W-1:0] child_pos_y;
    logic signed [POS_W-1:0] child_pos_z;
    logic signed [ROT_W-1:0] child_rot_x;
    logic signed [ROT_W-1:0] child_rot_y;
    logic signed [ROT_W-1:0] child_rot_z;
    logic signed [ROT_W-1:0] child_rot_w;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] local_pos_x;
    logic signed [POS_W-1:0] local_pos_y;
    logic signed [POS_W-1:0] local_pos_z;
    logic signed [ROT_W-1:0] local_rot_x;
    logic signed [ROT_W-1:0] local_rot_y;
    logic signed [ROT_W-1:0] local_rot_z;
    logic signed [ROT_W-1:0] local_rot_w;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [ROT_W-1:0] rot_x;
    logic signed [ROT_W-1:0] rot_y;
    logic signed [ROT_W-1:0] rot_z;
    logic signed [ROT_W-1:0] rot_w;
  } parent_t;

endpackage

`default_nettype wire

// ===== rtl/transform_to_local_space.sv =====
// ----------------------------------------------------------------------------
// transform_to_local_space
// child transform into the local space of a parent transform held in
// registers: local_pos = conj(P)*(C_pos - P_pos)*P, local_rot = conj(P)*C
//
// channel   ports                              beat when
// input     start, busy, in_item               start && !busy
// result    out_valid, out_item                out_valid
// config    cfg_we, cfg_idx, cfg_wdata         cfg_we
//
// one item per cycle
// start passes the difference, two rounds of multipliers and the final add and saturate before out_valid
// busy stays low: the pipeline takes a beat every cycle
// results are shown for one cycle; the receiver cannot hold them off
// reset clears the stage valid bits and loads the identity parent transform
// ----------------------------------------------------------------------------
`default_nettype none

module transform_to_local_space (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire ttls_pkg::in_item_t                   in_item,
  output logic                                      out_valid,
  output ttls_pkg::out_item_t                       out_item,
  input  wire logic                                 cfg_we,
  input  wire logic [ttls_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [ttls_pkg::POS_W-1:0]           cfg_wdata
);

  ttls_pkg::parent_t parent_r;
  ttls_pkg::parent_t parent_nxt;

  always_comb begin
    parent_nxt = parent_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        ttls_pkg::REG_POS_X: parent_nxt.pos_x = cfg_wdata;
        ttls_pkg::REG_POS_Y: parent_nxt.pos_y = cfg_wdata;
        ttls_pkg::REG_POS_Z: parent_nxt.pos_z = cfg_wdata;
        ttls_pkg::REG_ROT_X: parent_nxt.rot_x = cfg_wdata[ttls_pkg::ROT_W-1:0];
        ttls_pkg::REG_ROT_Y: parent_nxt.rot_y = cfg_wdata[ttls_pkg::ROT_W-1:0];
        ttls_pkg::REG_ROT_Z: parent_nxt.rot_z = cfg_wdata[ttls_pkg::ROT_W-1:0];
        ttls_pkg::REG_ROT_W: parent_nxt.rot_w = cfg_wdata[ttls_pkg::ROT_W-1:0];
        default: parent_nxt = parent_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parent_r.pos_x <= '0;
      parent_r.pos_y <= '0;
      parent_r.pos_z <= '0;
      parent_r.rot_x <= '0;
      parent_r.rot_y <= '0;
      parent_r.rot_z <= '0;
      parent_r.rot_w <= ttls_pkg::ROT_ONE;
    end else begin
      parent_r <= parent_nxt;
    end
  end

  assign busy = 1'b0;

  ttls_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_item   (in_item),
    .parent    (parent_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/ttls_pipe.sv =====
// ----------------------------------------------------------------------------
// ttls_pipe
// four stage datapath: difference, conj(P)*d and conj(P)*C, products with P,
// sum with rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module ttls_pipe (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire ttls_pkg::in_item_t in_item,
  input  wire ttls_pkg::parent_t  parent,
  output logic                    out_valid,
  output ttls_pkg::out_item_t     out_item
);

  localparam int POS_W = ttls_pkg::POS_W;
  localparam int ROT_W = ttls_pkg::ROT_W;
  localparam int D_W = POS_W + 1;
  localparam int T_W = D_W + ROT_W + 2;
  localparam int P_W = T_W + ROT_W;
  localparam int S_W = P_W + 3;
  localparam int L_W = 2 * ROT_W + 2;
  localparam int POS_SH = 28;
  localparam int ROT_SH = 14;

  localparam logic signed [S_W-1:0] POS_HALF = S_W'(64'sd1 <<< (POS_SH - 1));
  localparam logic signed [S_W-1:0] POS_MAX = S_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
  localparam logic signed [S_W-1:0] POS_MIN = S_W'(-(64'sd1 <<< (POS_W - 1)));
  localparam logic signed [L_W-1:0] ROT_HALF = L_W'(64'sd1 <<< (ROT_SH - 1));
  localparam logic signed [L_W-1:0] ROT_MAX = L_W'(ttls_pkg::ROT_ONE);
  localparam logic signed [L_W-1:0] ROT_MIN = -L_W'(ttls_pkg::ROT_ONE);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [S_W-1:0] v);
    logic signed [S_W-1:0] b;
    b = (v + POS_HALF) >>> POS_SH;
    if (b > POS_MAX) begin
      b = POS_MAX;
    end else if (b < POS_MIN) begin
      b = POS_MIN;
    end
    return b[POS_W-1:0];
  endfunction

  function automatic logic signed [ROT_W-1:0] sat_rot(input logic signed [L_W-1:0] v);
    logic signed [L_W-1:0] b;
    b = (v + ROT_HALF) >>> ROT_SH;
    if (b > ROT_MAX) begin
      b = ROT_MAX;
    end else if (b < ROT_MIN) begin
      b = ROT_MIN;
    end
    return b[ROT_W-1:0];
  endfunction

  logic signed [ROT_W-1:0] px, py, pz, pw;

  assign px = parent.rot_x;
  assign py = parent.rot_y;
  assign pz = parent.rot_z;
  assign pw = parent.rot_w;

  // stage 1: position difference
  logic                    v1_r;
  logic signed [D_W-1:0]   d0_r, d1_r, d2_r;
  logic signed [ROT_W-1:0] c0_r, c1_r, c2_r, c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= D_W'(in_item.child_pos_x) - D_W'(parent.pos_x);
    d1_r <= D_W'(in_item.child_pos_y) - D_W'(parent.pos_y);
    d2_r <= D_W'(in_item.child_pos_z) - D_W'(parent.pos_z);
    c0_r <= in_item.child_rot_x;
    c1_r <= in_item.child_rot_y;
    c2_r <= in_item.child_rot_z;
    c3_r <= in_item.child_rot_w;
  end

  // stage 2: t = conj(P)*d and lr = conj(P)*C
  logic                  v2_r;
  logic signed [T_W-1:0] t0_r, t1_r, t2_r, t3_r;
  logic signed [L_W-1:0] l0_r, l1_r, l2_r, l3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    t0_r <= T_W'(pw) * T_W'(d0_r) - T_W'(py) * T_W'(d2_r) + T_W'(pz) * T_W'(d1_r);
    t1_r <= T_W'(pw) * T_W'(d1_r) + T_W'(px) * T_W'(d2_r) - T_W'(pz) * T_W'(d0_r);
    t2_r <= T_W'(pw) * T_W'(d2_r) - T_W'(px) * T_W'(d1_r) + T_W'(py) * T_W'(d0_r);
    t3_r <= T_W'(px) * T_W'(d0_r) + T_W'(py) * T_W'(d1_r) + T_W'(pz) * T_W'(d2_r);
    l0_r <= L_W'(pw) * L_W'(c0_r) - L_W'(px) * L_W'(c3_r)
          - L_W'(py) * L_W'(c2_r) + L_W'(pz) * L_W'(c1_r);
    l1_r <= L_W'(pw) * L_W'(c1_r) + L_W'(px) * L_W'(c2_r)
          - L_W'(py) * L_W'(c3_r) - L_W'(pz) * L_W'(c0_r);
    l2_r <= L_W'(pw) * L_W'(c2_r) - L_W'(px) * L_W'(c1_r)
          + L_W'(py) * L_W'(c0_r) - L_W'(pz) * L_W'(c3_r);
    l3_r <= L_W'(pw) * L_W'(c3_r) + L_W'(px) * L_W'(c0_r)
          + L_W'(py) * L_W'(c1_r) + L_W'(pz) * L_W'(c2_r);
  end

  // stage 3: partial products of t*P
  logic                  v3_r;
  logic signed [P_W-1:0] m_r [3][4];
  logic signed [L_W-1:0] l0_d_r, l1_d_r, l2_d_r, l3_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    m_r[0][0] <= P_W'(t3_r) * P_W'(px);
    m_r[0][1] <= P_W'(t0_r) * P_W'(pw);
    m_r[0][2] <= P_W'(t1_r) * P_W'(pz);
    m_r[0][3] <= -(P_W'(t2_r) * P_W'(py));
    m_r[1][0] <= P_W'(t3_r) * P_W'(py);
    m_r[1][1] <= -(P_W'(t0_r) * P_W'(pz));
    m_r[1][2] <= P_W'(t1_r) * P_W'(pw);
    m_r[1][3] <= P_W'(t2_r) * P_W'(px);
    m_r[2][0] <= P_W'(t3_r) * P_W'(pz);
    m_r[2][1] <= P_W'(t0_r) * P_W'(py);
    m_r[2][2] <= -(P_W'(t1_r) * P_W'(px));
    m_r[2][3] <= P_W'(t2_r) * P_W'(pw);
    l0_d_r <= l0_r;
    l1_d_r <= l1_r;
    l2_d_r <= l2_r;
    l3_d_r <= l3_r;
  end

  // stage 4: sum, round, saturate
  logic signed [S_W-1:0] u_sum [3];
  logic                  out_valid_r;
  ttls_pkg::out_item_t   out_item_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_sum[k] = S_W'(m_r[k][0]) + S_W'(m_r[k][1]) + S_W'(m_r[k][2]) + S_W'(m_r[k][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.local_pos_x <= sat_pos(u_sum[0]);
    out_item_r.local_pos_y <= sat_pos(u_sum[1]);
    out_item_r.local_pos_z <= sat_pos(u_sum[2]);
    out_item_r.local_rot_x <= sat_rot(l0_d_r);
    out_item_r.local_rot_y <= sat_rot(l1_d_r);
    out_item_r.local_rot_z <= sat_rot(l2_d_r);
    out_item_r.local_rot_w <= sat_rot(l3_d_r);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== tb/ttls_checker.sv =====
// ----------------------------------------------------------------------------
// ttls_checker
// Watches the input, result and register ports of transform_to_local_space.
// Each accepted child transform is run through a fixed-point predictor
// (exact Hamilton products, round half up, saturate) using a shadow copy of
// the parent registers. Each result beat is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttls_checker
  import ttls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [POS_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   n_checked
);

  localparam longint POS_MAX = 64'sd8388607;
  localparam longint POS_MIN = -64'sd8388608;
  localparam longint ROT_LIM = 64'sd16384;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] w;
  } quat_t;

  parent_t   parent_shadow;
  out_item_t local_queue[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    n_checked  = 0;
  end

  function automatic quat_t hamilton(quat_t a, quat_t b);
    quat_t r;
    r.x = a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y;
    r.y = a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x;
    r.z = a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w;
    r.w = a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z;
    return r;
  endfunction

  function automatic longint round_sat(longint v, int sh, longint lo, longint hi);
    longint one;
    longint q;
    one = 1;
    q = (v + (one << (sh - 1))) >>> sh;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q;
  endfunction

  function automatic out_item_t to_local(in_item_t c, parent_t par);
    quat_t     p, pc, cr, d, t, u, lr;
    out_item_t o;
    p.x = 64'(par.rot_x);
    p.y = 64'(par.rot_y);
    p.z = 64'(par.rot_z);
    p.w = 64'(par.rot_w);
    pc.x = -p.x;
    pc.y = -p.y;
    pc.z = -p.z;
    pc.w = p.w;
    cr.x = 64'(c.child_rot_x);
    cr.y = 64'(c.child_rot_y);
    cr.z = 64'(c.child_rot_z);
    cr.w = 64'(c.child_rot_w);
    d.x = longint'(c.child_pos_x) - longint'(par.pos_x);
    d.y = longint'(c.child_pos_y) - longint'(par.pos_y);
    d.z = longint'(c.child_pos_z) - longint'(par.pos_z);
    d.w = '0;
    t  = hamilton(pc, d);
    u  = hamilton(t, p);
    lr = hamilton(pc, cr);
    o.local_pos_x = POS_W'(round_sat(u.x, 28, POS_MIN, POS_MAX));
    o.local_pos_y = POS_W'(round_sat(u.y, 28, POS_MIN, POS_MAX));
    o.local_pos_z = POS_W'(round_sat(u.z, 28, POS_MIN, POS_MAX));
    o.local_rot_x = ROT_W'(round_sat(lr.x, 14, -ROT_LIM, ROT_LIM));
    o.local_rot_y = ROT_W'(round_sat(lr.y, 14, -ROT_LIM, ROT_LIM));
    o.local_rot_z = ROT_W'(round_sat(lr.z, 14, -ROT_LIM, ROT_LIM));
    o.local_rot_w = ROT_W'(round_sat(lr.w, 14, -ROT_LIM, ROT_LIM));
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    if (fail_count < 30)
      $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic compare_beat(out_item_t got, out_item_t want);
    if (got.local_pos_x !== want.local_pos_x)
      report("local_pos_x", longint'(got.local_pos_x), longint'(want.local_pos_x));
    if (got.local_pos_y !== want.local_pos_y)
      report("local_pos_y", longint'(got.local_pos_y), longint'(want.local_pos_y));
    if (got.local_pos_z !== want.local_pos_z)
      report("local_pos_z", longint'(got.local_pos_z), longint'(want.local_pos_z));
    if (got.local_rot_x !== want.local_rot_x)
      report("local_rot_x", longint'(got.local_rot_x), longint'(want.local_rot_x));
    if (got.local_rot_y !== want.local_rot_y)
      report("local_rot_y", longint'(got.local_rot_y), longint'(want.local_rot_y));
    if (got.local_rot_z !== want.local_rot_z)
      report("local_rot_z", longint'(got.local_rot_z), longint'(want.local_rot_z));
    if (got.local_rot_w !== want.local_rot_w)
      report("local_rot_w", longint'(got.local_rot_w), longint'(want.local_rot_w));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      parent_shadow = '0;
      parent_shadow.rot_w = ROT_ONE;
      local_queue.delete();
    end else begin
      if (out_valid) begin
        if (local_queue.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          compare_beat(out_item, local_queue.pop_front());
          n_checked++;
        end
      end
      if (start && !busy)
        local_queue.push_back(to_local(in_item, parent_shadow));
      if (cfg_we) begin
        case (cfg_idx)
          REG_POS_X: parent_shadow.pos_x = cfg_wdata;
          REG_POS_Y: parent_shadow.pos_y = cfg_wdata;
          REG_POS_Z: parent_shadow.pos_z = cfg_wdata;
          REG_ROT_X: parent_shadow.rot_x = cfg_wdata[ROT_W-1:0];
          REG_ROT_Y: parent_shadow.rot_y = cfg_wdata[ROT_W-1:0];
          REG_ROT_Z: parent_shadow.rot_z = cfg_wdata[ROT_W-1:0];
          REG_ROT_W: parent_shadow.rot_w = cfg_wdata[ROT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = local_queue.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for transform_to_local_space. A directed set of
// extreme child transforms runs under the reset parent and a few extreme
// parents, then random child transforms run under a series of random parent
// settings, sent in bursts with random gaps. ttls_checker does the checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ttls_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 100;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
    logic signed [ROT_W-1:0] w;
  } rot_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [POS_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   pending;
  int                   n_checked;
  int                   idle_cycles = 0;
  int                   n_items = 0;
  int                   n_settings = 0;

  always #4 clk = ~clk;

  transform_to_local_space u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  ttls_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_checked  (n_checked)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return POS_W'($urandom_range(0, 4095) - 2048);
      1: begin
        case ($urandom_range(0, 3))
          0: return 24'sh7fffff;
          1: return 24'sh800000;
          2: return 24'sh000000;
          default: return 24'shffffff;
        endcase
      end
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [ROT_W-1:0] rand_rot();
    case ($urandom_range(0, 4))
      0, 1: return ROT_W'($urandom_range(0, 32768) - 16384);
      2: return ROT_W'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'sd16384;
          1: return -16'sd16384;
          2: return 16'sh8000;
          3: return 16'sh7fff;
          default: return 16'sd0;
        endcase
      end
    endcase
  endfunction

  function automatic rot_t unit_rot();
    real  a [4];
    real  n;
    rot_t r;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      a[i] = real'($urandom_range(0, 2000)) - 1000.0;
      n = n + a[i] * a[i];
    end
    if (n < 1.0) begin
      r = '0;
      r.w = ROT_ONE;
      return r;
    end
    n = $sqrt(n);
    r.x = ROT_W'($rtoi(a[0] / n * 16384.0));
    r.y = ROT_W'($rtoi(a[1] / n * 16384.0));
    r.z = ROT_W'($rtoi(a[2] / n * 16384.0));
    r.w = ROT_W'($rtoi(a[3] / n * 16384.0));
    return r;
  endfunction

  function automatic in_item_t mk_child(logic signed [POS_W-1:0] px, py, pz, rot_t r);
    in_item_t c;
    c.child_pos_x = px;
    c.child_pos_y = py;
    c.child_pos_z = pz;
    c.child_rot_x = r.x;
    c.child_rot_y = r.y;
    c.child_rot_z = r.z;
    c.child_rot_w = r.w;
    return c;
  endfunction

  function automatic in_item_t rand_child();
    rot_t r;
    if ($urandom_range(0, 9) < 6) begin
      r = unit_rot();
    end else begin
      r.x = rand_rot();
      r.y = rand_rot();
      r.z = rand_rot();
      r.w = rand_rot();
    end
    return mk_child(rand_pos(), rand_pos(), rand_pos(), r);
  endfunction

  function automatic parent_t mk_parent(logic signed [POS_W-1:0] px, py, pz, rot_t r);
    parent_t p;
    p.pos_x = px;
    p.pos_y = py;
    p.pos_z = pz;
    p.rot_x = r.x;
    p.rot_y = r.y;
    p.rot_z = r.z;
    p.rot_w = r.w;
    return p;
  endfunction

  // one beat, then a gap with start low
  task automatic send(in_item_t c, int gap);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= c;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    n_items++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  // junk in the upper bits of rotation writes must be dropped
  task automatic load_parent(parent_t p, bit stray_write);
    wait_idle();
    write_reg(REG_POS_X, p.pos_x);
    write_reg(REG_ROT_X, {8'($urandom), p.rot_x});
    write_reg(REG_POS_Y, p.pos_y);
    write_reg(REG_ROT_Y, {8'($urandom), p.rot_y});
    write_reg(REG_POS_Z, p.pos_z);
    write_reg(REG_ROT_Z, {8'($urandom), p.rot_z});
    write_reg(REG_ROT_W, {8'($urandom), p.rot_w});
    if (stray_write) write_reg(REG_NONE, POS_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_burst_run(int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++) begin
        if (k == burst - 1)
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        else
          gap = ($urandom_range(0, 7) == 0) ? 1 : 0;
        send(rand_child(), gap);
      end
      left -= burst;
    end
  endtask

  initial begin
    rot_t    ident, neg_ident, rot90z, r_big, r_neg, r_mix;
    parent_t p;

    ident     = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: 16'sd16384};
    neg_ident = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: -16'sd16384};
    rot90z    = '{x: 16'sd0, y: 16'sd0, z: 16'sd11585, w: 16'sd11585};
    r_big     = '{x: 16'sd16384, y: 16'sd16384, z: 16'sd16384, w: 16'sd16384};
    r_neg     = '{x: -16'sd16384, y: -16'sd16384, z: -16'sd16384, w: -16'sd16384};
    r_mix     = '{x: 16'sh8000, y: 16'sh7fff, z: 16'sh8000, w: 16'sh7fff};

    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_POS_X;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset parent: identity rotation at the origin
    send(mk_child(24'sd0, 24'sd0, 24'sd0, ident), 0);
    send(mk_child(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, r_big), 1);
    send(mk_child(24'sh800000, 24'sh800000, 24'sh800000, r_neg), 0);
    send(mk_child(24'sd256, -24'sd256, 24'sd1, r_mix), 2);
    send(mk_child(24'shffffff, 24'sd0, 24'sh7fffff, rot90z), 0);
    send(rand_child(), 0);

    // far negative parent: child at the positive end overflows upward
    load_parent(mk_parent(24'sh800000, 24'sh800000, 24'sh800000, ident), 1'b1);
    send(mk_child(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, ident), 0);
    send(mk_child(24'sh800000, 24'sh800000, 24'sh800000, neg_ident), 0);
    send(mk_child(24'sd0, 24'sh7fffff, 24'sh800000, r_mix), 3);

    // far positive parent with negated identity rotation
    load_parent(mk_parent(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, neg_ident), 1'b1);
    send(mk_child(24'sh800000, 24'sh800000, 24'sh800000, r_big), 0);
    send(mk_child(24'sh7fffff, 24'sd0, 24'sh800000, r_neg), 0);
    send(mk_child(24'sd0, 24'sd0, 24'sd0, ident), 1);

    // non-unit parent at the raw two's complement extremes
    load_parent(mk_parent(24'sd0, 24'sh7fffff, 24'sh800000, r_mix), 1'b1);
    send(mk_child(24'sh7fffff, 24'sh800000, 24'sd0, r_mix), 0);
    send(mk_child(24'sh800000, 24'sh7fffff, 24'sh7fffff, r_big), 0);
    send(mk_child(24'sd1, -24'sd1, 24'sd128, r_neg), 0);
    send(mk_child(24'sd0, 24'sd0, 24'sd0, ident), 2);

    // quarter turn about z at a modest offset
    load_parent(mk_parent(24'sd2560, -24'sd512, 24'sd77, rot90z), 1'b1);
    send(mk_child(24'sd2816, -24'sd512, 24'sd77, ident), 0);
    send(mk_child(24'sd0, 24'sd0, 24'sd0, rot90z), 0);
    send(rand_child(), 4);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: p = mk_parent(rand_pos(), rand_pos(), rand_pos(), unit_rot());
        1: p = mk_parent(POS_W'($urandom_range(0, 8191) - 4096),
                         POS_W'($urandom_range(0, 8191) - 4096),
                         POS_W'($urandom_range(0, 8191) - 4096), unit_rot());
        2: p = mk_parent(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                         '{x: rand_rot(), y: rand_rot(), z: rand_rot(), w: rand_rot()});
        default: p = mk_parent(rand_pos(), rand_pos(), rand_pos(), ident);
      endcase
      load_parent(p, 1'($urandom));
      random_burst_run(PHASE_ITEMS);
    end

    wait_idle();
    $display("sent %0d child transforms under %0d parent settings", n_items, n_settings + 1);
    $display("compared %0d local transforms, %0d field mismatches", n_checked, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ttls_pkg.sv
rtl/ttls_pipe.sv
rtl/transform_to_local_space.sv
tb/ttls_checker.sv
tb/tb_top.sv
